// File: hdl/waypoint_heading_pid_guidance_assert.svh
// Assertion macros for the waypoint guidance block.
`ifndef WAYPOINT_HEADING_PID_GUIDANCE_ASSERT_SVH
`define WAYPOINT_HEADING_PID_GUIDANCE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define WHPG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define WHPG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/whpg_pkg.sv
// ----------------------------------------------------------------------------
// whpg_pkg
// Types and constants shared by the waypoint guidance modules.
// ----------------------------------------------------------------------------
package whpg_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TBL_LEN = 32;

    localparam logic [1:0] CFG_KP = 2'd0;
    localparam logic [1:0] CFG_KI = 2'd1;
    localparam logic [1:0] CFG_KD = 2'd2;

    typedef struct packed {
        logic signed [31:0] pos_north;
        logic signed [31:0] pos_east;
        logic signed [31:0] target_north;
        logic signed [31:0] target_east;
        logic        [15:0] heading;
    } t_in;

    typedef struct packed {
        logic        [15:0] bearing;
        logic        [31:0] range_to_target;
        logic signed [15:0] turn_command;
        logic        [14:0] speed_command;
    } t_out;

    // atan(2^-i) in 1/256 centidegree
    function automatic logic [20:0] atan_tab(input logic [4:0] i);
        logic [20:0] v;
        case (i)
            5'd0: v = 21'd1152000; 5'd1: v = 21'd680065; 5'd2: v = 21'd359328;
            5'd3: v = 21'd182400;  5'd4: v = 21'd91554;  5'd5: v = 21'd45822;
            5'd6: v = 21'd22916;   5'd7: v = 21'd11459;  5'd8: v = 21'd5730;
            5'd9: v = 21'd2865;    5'd10: v = 21'd1432;  5'd11: v = 21'd716;
            5'd12: v = 21'd358;    5'd13: v = 21'd179;   5'd14: v = 21'd90;
            5'd15: v = 21'd45;     5'd16: v = 21'd22;    5'd17: v = 21'd11;
            5'd18: v = 21'd6;      5'd19: v = 21'd3;     5'd20: v = 21'd1;
            5'd21: v = 21'd1;
            default: v = 21'd0;
        endcase
        return v;
    endfunction

endpackage

// File: hdl/waypoint_heading_pid_guidance.sv
// ----------------------------------------------------------------------------
// waypoint_heading_pid_guidance
// Bearing, range and PID turn/speed commands for one control tick.
// ----------------------------------------------------------------------------
// One input beat per control tick; exactly one output beat per input beat.
// The block works one beat at a time. The next input beat can be taken
// in the cycle after the result register loads. The time per beat is set
// by the serial square root (one result bit per cycle), the CORDIC (one
// rotation per cycle plus a closing step) and five passes through the
// shared multiplier for the squares and the PID terms, each pass made of
// a launch, four partial products and a collect. The result sits in its
// own register: i_stall holds it there while the next beat is already
// being worked on, and a finished beat waits in the last state until the
// register is free. Gains are to be written on the plain write port only
// while the block is idle; the block itself does not enforce this.
module waypoint_heading_pid_guidance #(
    parameter int CORDIC_STEPS = whpg_pkg::CORDIC_STEPS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  whpg_pkg::t_in     i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output whpg_pkg::t_out    o_data,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [31:0]       i_cfg_data
);
    localparam int NSTEP = (CORDIC_STEPS > whpg_pkg::TBL_LEN) ? whpg_pkg::TBL_LEN
                                                               : CORDIC_STEPS;
    localparam int SW = $clog2(whpg_pkg::TBL_LEN + 1);

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SQN  = 4'd1;  // dn^2
    localparam logic [3:0] S_SQE  = 4'd2;  // de^2
    localparam logic [3:0] S_SQRT = 4'd3;
    localparam logic [3:0] S_CORD = 4'd4;
    localparam logic [3:0] S_ERR  = 4'd5;
    localparam logic [3:0] S_KP   = 4'd6;
    localparam logic [3:0] S_KI   = 4'd7;
    localparam logic [3:0] S_KD   = 4'd8;
    localparam logic [3:0] S_SPD  = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    logic [3:0] r_state, n_state;
    logic       r_busy;   // multiplier launched in this state

    logic signed [31:0] r_kp, r_ki, r_kd;
    logic signed [15:0] r_integ, r_prev;

    logic signed [32:0] r_dn, r_de;
    logic        [15:0] r_hd;
    logic        [65:0] r_sum;     // dn^2 + de^2, up to 2^65
    logic        [65:0] r_rem;
    logic        [32:0] r_root;
    logic        [5:0]  r_cnt;

    logic signed [55:0] r_x, r_y;
    logic signed [24:0] r_z;
    logic [SW-1:0]      r_i;

    logic        [15:0] r_brg;
    logic signed [16:0] r_e;
    logic signed [69:0] r_acc;
    logic        [31:0] r_range;

    logic               r_ovalid;
    whpg_pkg::t_out     r_out;

    // shared multiplier
    logic               w_mstart, w_mdone;
    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_mp;

    whpg_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_mstart),
        .i_a    (w_ma),
        .i_b    (w_mb),
        .o_done (w_mdone),
        .o_p    (w_mp)
    );

    always_comb begin
        w_ma = 33'sd0;
        w_mb = 33'sd0;
        case (r_state)
            S_SQN: begin
                w_ma = r_dn;
                w_mb = r_dn;
            end
            S_SQE: begin
                w_ma = r_de;
                w_mb = r_de;
            end
            S_KP: begin
                w_ma = 33'(r_kp);
                w_mb = 33'(r_e);
            end
            S_KI: begin
                w_ma = 33'(r_ki);
                w_mb = 33'(r_integ);
            end
            S_KD: begin
                w_ma = 33'(r_kd);
                w_mb = 33'(r_e - 17'(r_prev)) * 33'sd5;
            end
            default: begin
                w_ma = 33'sd0;
                w_mb = 33'sd0;
            end
        endcase
    end
    // kd term input: 5*(e - prev) fits easily in 33 bits

    assign w_mstart = !r_busy && (r_state == S_SQN || r_state == S_SQE ||
                      r_state == S_KP || r_state == S_KI || r_state == S_KD);

    // sqrt step: test bit from the top of the 66-bit sum, two bits at a time
    logic [67:0] w_trial;
    logic [67:0] w_remsh;
    always_comb begin
        w_remsh = {r_rem[65:0], r_sum[65:64]};
        w_trial = w_remsh - {33'd0, r_root, 2'b01};
    end

    // CORDIC step
    logic signed [55:0] w_xs, w_ys;
    assign w_xs = r_x >>> r_i;
    assign w_ys = r_y >>> r_i;

    // error path
    logic signed [17:0] w_e0;
    logic        [15:0] w_hd;
    logic signed [24:0] w_zr;
    logic signed [16:0] w_cd;
    always_comb begin
        w_hd = (r_hd >= 16'd36000) ? r_hd - 16'd36000 : r_hd;
        w_zr = (r_z + 25'sd128) >>> 8;
        w_cd = 17'(w_zr);
        if (w_cd < 17'sd0) begin
            w_cd = w_cd + 17'sd36000;
        end else if (w_cd >= 17'sd36000) begin
            w_cd = w_cd - 17'sd36000;
        end
        w_e0 = 18'(r_brg) - 18'($signed({1'b0, w_hd}));
        if (w_e0 > 18'sd18000) begin
            w_e0 = w_e0 - 18'sd36000;
        end else if (w_e0 < -18'sd18000) begin
            w_e0 = w_e0 + 18'sd36000;
        end
    end

    // round(e/5) via reciprocal: (a+2)*52429 >> 18 exact for a+2 < 262144
    logic        [16:0] w_ae;
    logic        [31:0] w_qm;
    logic signed [15:0] w_inc;
    logic signed [16:0] w_isum;
    always_comb begin
        w_ae = r_e[16] ? 17'(-r_e) : 17'(r_e);
        w_qm = 32'(w_ae + 17'd2) * 32'd52429;
        w_inc = r_e[16] ? -16'(w_qm[31:18]) : 16'(w_qm[31:18]);
        w_isum = 17'(r_integ) + 17'(w_inc);
    end

    // turn command rounding and saturation
    logic signed [69:0] w_tr;
    logic signed [15:0] w_turn;
    always_comb begin
        w_tr = (r_acc + 70'sd32768) >>> 16;
        if (w_tr > 70'sd16384) begin
            w_turn = 16'sd16384;
        end else if (w_tr < -70'sd16384) begin
            w_turn = -16'sd16384;
        end else begin
            w_turn = 16'(w_tr);
        end
    end

    // speed: range*64/10 = 32*range/5 capped; range >= 2560 already caps
    logic [31:0] w_sp;
    logic [14:0] w_speed;
    always_comb begin
        w_sp = 32'({r_range[11:0], 5'b00000}) * 32'd52429; // >> 18 is exact /5 here
        if (r_range >= 32'd2560) begin
            w_speed = 15'd16384;
        end else begin
            w_speed = 15'(w_sp >> 18);
        end
    end

    // result register free (empty, or its beat leaves this cycle)
    logic w_load;
    assign w_load = (r_state == S_OUT) && (!r_ovalid || !i_stall);

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid && !o_stall) n_state = S_SQN;
            S_SQN:  if (r_busy && w_mdone) n_state = S_SQE;
            S_SQE:  if (r_busy && w_mdone) n_state = S_SQRT;
            S_SQRT: if (r_cnt == 6'd32) n_state = S_CORD;
            S_CORD: if (32'(r_i) >= 32'(NSTEP)) n_state = S_ERR;
            S_ERR:  n_state = S_KP;
            S_KP:   if (r_busy && w_mdone) n_state = S_KI;
            S_KI:   if (r_busy && w_mdone) n_state = S_KD;
            S_KD:   if (r_busy && w_mdone) n_state = S_SPD;
            S_SPD:  n_state = S_OUT;
            S_OUT:  if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_kp     <= 32'sd0;
            r_ki     <= 32'sd0;
            r_kd     <= 32'sd0;
            r_integ  <= 16'sd0;
            r_prev   <= 16'sd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (n_state != r_state) begin
                r_busy <= 1'b0;
            end else if (w_mstart) begin
                r_busy <= 1'b1;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    whpg_pkg::CFG_KP: r_kp <= i_cfg_data;
                    whpg_pkg::CFG_KI: r_ki <= i_cfg_data;
                    whpg_pkg::CFG_KD: r_kd <= i_cfg_data;
                    default: ;
                endcase
            end
            // integral steps once, on the launch cycle of the kp pass,
            // when the new error is already in r_e
            if (r_state == S_KP && !r_busy) begin
                if (w_isum > 17'sd5000) begin
                    r_integ <= 16'sd5000;
                end else if (w_isum < -17'sd5000) begin
                    r_integ <= -16'sd5000;
                end else begin
                    r_integ <= 16'(w_isum);
                end
            end
            if (r_state == S_SPD) begin
                r_prev <= 16'(r_e);
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_dn <= 33'(i_data.target_north) - 33'(i_data.pos_north);
                r_de <= 33'(i_data.target_east) - 33'(i_data.pos_east);
                r_hd <= i_data.heading;
            end
            S_SQN: begin
                if (r_busy && w_mdone) begin
                    r_sum <= 66'(w_mp);
                end
            end
            S_SQE: begin
                r_rem  <= 66'd0;
                r_root <= 33'd0;
                r_cnt  <= 6'd0;
                if (r_busy && w_mdone) begin
                    r_sum <= r_sum + 66'(w_mp);
                end
                // CORDIC prerotation
                r_i <= '0;
                if (r_dn < 0) begin
                    if (r_de >= 0) begin
                        r_x <= 56'(r_de) <<< 20;
                        r_y <= -(56'(r_dn) <<< 20);
                        r_z <= 25'sd2304000;
                    end else begin
                        r_x <= -(56'(r_de) <<< 20);
                        r_y <= 56'(r_dn) <<< 20;
                        r_z <= -25'sd2304000;
                    end
                end else begin
                    r_x <= 56'(r_dn) <<< 20;
                    r_y <= 56'(r_de) <<< 20;
                    r_z <= 25'sd0;
                end
            end
            S_SQRT: begin
                r_sum <= {r_sum[63:0], 2'b00};
                r_cnt <= r_cnt + 6'd1;
                if (!w_trial[67]) begin
                    r_rem  <= w_trial[65:0];
                    r_root <= {r_root[31:0], 1'b1};
                end else begin
                    r_rem  <= w_remsh[65:0];
                    r_root <= {r_root[31:0], 1'b0};
                end
            end
            S_CORD: begin
                if (32'(r_i) < 32'(NSTEP)) begin
                    r_i <= r_i + SW'(1);
                    if (r_y > 0) begin
                        r_x <= r_x + w_ys;
                        r_y <= r_y - w_xs;
                        r_z <= r_z + 25'(whpg_pkg::atan_tab(5'(r_i)));
                    end else begin
                        r_x <= r_x - w_ys;
                        r_y <= r_y + w_xs;
                        r_z <= r_z - 25'(whpg_pkg::atan_tab(5'(r_i)));
                    end
                end else begin
                    r_brg <= (r_dn == 0 && r_de == 0) ? 16'd0 : 16'(w_cd);
                    r_range <= r_root[32] ? 32'hFFFF_FFFF : r_root[31:0];
                end
            end
            S_ERR: begin
                r_e <= 17'(w_e0);
                r_acc <= 70'sd0;
            end
            S_KP, S_KI, S_KD: begin
                if (r_busy && w_mdone) begin
                    r_acc <= r_acc + 70'(w_mp);
                end
            end
            S_OUT: begin
                if (w_load) begin
                    r_out.bearing <= r_brg;
                    r_out.range_to_target <= r_range;
                    r_out.turn_command <= w_turn;
                    r_out.speed_command <= w_speed;
                end
            end
            default: ;
        endcase
    end
endmodule

// File: hdl/whpg_mul.sv
// ----------------------------------------------------------------------------
// whpg_mul
// Shared 33x33 signed multiplier, split over four 17x17-ish partial products.
// ----------------------------------------------------------------------------
module whpg_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    output logic               o_done,
    output logic signed [65:0] o_p
);
    // a = ah*2^16 + al, al unsigned 16 bits; one partial product per cycle
    logic signed [16:0] r_ah, r_bh;
    logic        [15:0] r_al, r_bl;
    logic        [2:0]  r_cnt;
    logic signed [65:0] r_acc;
    logic signed [17:0] w_x, w_y;
    logic signed [35:0] w_pp;
    logic signed [65:0] w_sh;

    always_comb begin
        w_x = 18'sd0;
        w_y = 18'sd0;
        w_sh = 66'sd0;
        case (r_cnt)
            3'd1: begin
                w_x = {2'b00, r_al};
                w_y = {2'b00, r_bl};
            end
            3'd2: begin
                w_x = {r_ah[16], r_ah};
                w_y = {2'b00, r_bl};
            end
            3'd3: begin
                w_x = {2'b00, r_al};
                w_y = {r_bh[16], r_bh};
            end
            default: begin
                w_x = {r_ah[16], r_ah};
                w_y = {r_bh[16], r_bh};
            end
        endcase
        w_pp = w_x * w_y;
        case (r_cnt)
            3'd1: w_sh = 66'(w_pp);
            3'd2, 3'd3: w_sh = 66'(w_pp) <<< 16;
            default: w_sh = 66'(w_pp) <<< 32;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (i_start) begin
            r_cnt <= 3'd1;
        end else if (r_cnt != 3'd0) begin
            r_cnt <= (r_cnt == 3'd4) ? 3'd0 : r_cnt + 3'd1;
        end
        if (i_start) begin
            r_ah <= i_a[32:16];
            r_al <= i_a[15:0];
            r_bh <= i_b[32:16];
            r_bl <= i_b[15:0];
            r_acc <= 66'sd0;
        end else if (r_cnt != 3'd0) begin
            r_acc <= r_acc + w_sh;
        end
    end

    assign o_done = (r_cnt == 3'd0) && !i_start;
    assign o_p = r_acc;
endmodule

// File: hdl/whpg_checker.sv
// ----------------------------------------------------------------------------
// whpg_checker
// Port-level checks for the waypoint guidance block, bound to the top level.
// ----------------------------------------------------------------------------
`include "waypoint_heading_pid_guidance_assert.svh"

module whpg_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_valid,
    input logic           o_stall,
    input logic           o_valid,
    input logic           i_stall,
    input whpg_pkg::t_out o_data
);
    `WHPG_ASSERT_IMPL(a_turn_range, i_clk, i_rst_n, o_valid, (o_data.turn_command <= 16'sd16384 && o_data.turn_command >= -16'sd16384))
    `WHPG_ASSERT_IMPL(a_speed_range, i_clk, i_rst_n, o_valid, (o_data.speed_command <= 15'd16384))
    `WHPG_ASSERT_IMPL(a_brg_range, i_clk, i_rst_n, o_valid, (o_data.bearing < 16'd36000))
    `WHPG_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, (i_valid && !o_stall), (o_stall))
    `WHPG_ASSERT_NEXT(a_hold, i_clk, i_rst_n, (o_valid && i_stall), (o_valid && $stable(o_data)))
endmodule

bind waypoint_heading_pid_guidance whpg_checker u_whpg_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .i_valid(i_valid),
    .o_stall(o_stall),
    .o_valid(o_valid),
    .i_stall(i_stall),
    .o_data (o_data)
);

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks waypoint_heading_pid_guidance beat by beat against its own predictor.
// A short directed table comes first, then random ticks under several gain
// settings, with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam logic [1:0] CFG_SPARE = 2'd3;   // no register behind this index
    localparam int         N_STEPS   = whpg_pkg::CORDIC_STEPS_DEF;
    localparam int         WDOG_MAX  = 5000;   // idle cycles before giving up
    localparam int         N_RANDOM  = 1830;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_valid;
    logic            o_stall;
    whpg_pkg::t_in   i_data;
    logic            o_valid;
    logic            i_stall;
    whpg_pkg::t_out  o_data;
    logic            i_cfg_we;
    logic [1:0]      i_cfg_idx;
    logic [31:0]     i_cfg_data;

    waypoint_heading_pid_guidance u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: gains and the PID memory, tracked beside the block
    // ------------------------------------------------------------------
    longint kp_gain, ki_gain, kd_gain;
    longint err_integral, last_error;
    whpg_pkg::t_out pending_cmds[$];   // expected output beats, oldest first

    int  mismatches;
    int  idle_cycles;
    bit  calm;                      // when set, neither side idles

    // atan(2^-i) in 1/256 centidegree
    localparam longint ATAN_LUT [0:21] = '{
        1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
        5730, 2865, 1432, 716, 358, 179, 90, 45, 22, 11, 6, 3, 1, 1
    };

    function automatic bit [63:0] int_sqrt(input bit [63:0] v);
        bit [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Vectoring CORDIC; bearing clockwise from north in centidegrees.
    function automatic longint bearing_cdeg(input longint dn, input longint de);
        longint x, y, z, t, xs, ys, cd;
        if (dn == 0 && de == 0) return 0;
        x = dn * (64'sd1 << 20);
        y = de * (64'sd1 << 20);
        z = 0;
        // pre-rotate into the right half plane
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;  y = -t; z = 2304000;
            end else begin
                x = -y; y = t;  z = -2304000;
            end
        end
        for (int i = 0; i < N_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x += ys; y -= xs; z += (i < 22) ? ATAN_LUT[i] : 0;
            end else begin
                x -= ys; y += xs; z -= (i < 22) ? ATAN_LUT[i] : 0;
            end
        end
        cd = (z + 128) >>> 8;
        while (cd < 0) cd += 36000;
        while (cd >= 36000) cd -= 36000;
        return cd;
    endfunction

    // One control tick: returns the command beat and advances PID memory.
    function automatic whpg_pkg::t_out guidance_tick(input whpg_pkg::t_in d);
        whpg_pkg::t_out r;
        longint    dn, de, hd, brg, e, inc, acc, cmd;
        bit [63:0] an, ae, sn, se, rng, spd;
        dn  = longint'(d.target_north) - longint'(d.pos_north);
        de  = longint'(d.target_east) - longint'(d.pos_east);
        hd  = longint'(d.heading);
        an  = (dn < 0) ? -dn : dn;
        ae  = (de < 0) ? -de : de;
        sn  = an * an;
        se  = ae * ae;
        if (sn > ~se) rng = 64'hFFFF_FFFF;
        else rng = int_sqrt(sn + se);
        if (rng > 64'hFFFF_FFFF) rng = 64'hFFFF_FFFF;

        brg = bearing_cdeg(dn, de);
        if (hd >= 36000) hd -= 36000;
        e = brg - hd;
        if (e > 18000) e -= 36000;
        if (e < -18000) e += 36000;

        inc = (e >= 0) ? (e + 2) / 5 : -((-e + 2) / 5);
        err_integral += inc;
        if (err_integral > 5000) err_integral = 5000;
        if (err_integral < -5000) err_integral = -5000;

        acc = kp_gain * e + ki_gain * err_integral + 5 * kd_gain * (e - last_error);
        cmd = (acc + 32768) >>> 16;
        if (cmd > 16384) cmd = 16384;
        if (cmd < -16384) cmd = -16384;
        last_error = e;

        spd = rng * 64 / 10;
        if (spd > 16384) spd = 16384;

        r.bearing         = brg[15:0];
        r.range_to_target = rng[31:0];
        r.turn_command    = cmd[15:0];
        r.speed_command   = spd[14:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Output side: random stall, checker and watchdog share one clock edge
    // ------------------------------------------------------------------
    int stall_left;

    always @(posedge i_clk) begin
        whpg_pkg::t_out want;
        if (!i_rst_n) begin
            i_stall     <= 1'b0;
            idle_cycles <= 0;
        end else begin
            // stall pattern: short bursts mostly, a long one now and then
            if (calm) begin
                stall_left = 0;
            end else if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
                stall_left = ($urandom_range(0, 24) == 0) ? $urandom_range(20, 250)
                                                          : $urandom_range(1, 3);
            end
            i_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;

            // a beat leaves the block here
            if (o_valid && !i_stall) begin
                if (pending_cmds.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output beat: %p", o_data);
                end else begin
                    want = pending_cmds.pop_front();
                    if (o_data.bearing !== want.bearing
                            || o_data.range_to_target !== want.range_to_target
                            || o_data.turn_command !== want.turn_command
                            || o_data.speed_command !== want.speed_command) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp brg %0d rng %0d turn %0d spd %0d",
                                      " / got brg %0d rng %0d turn %0d spd %0d"},
                                     want.bearing, want.range_to_target,
                                     want.turn_command, want.speed_command,
                                     o_data.bearing, o_data.range_to_target,
                                     o_data.turn_command, o_data.speed_command);
                    end
                end
            end

            // watchdog: any beat on either side clears it
            if ((o_valid && !i_stall) || (i_valid && !o_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WDOG_MAX) begin
                $display("TEST FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    task automatic send_tick(input whpg_pkg::t_in d, input bit typed,
                             input whpg_pkg::t_out typed_cmd);
        int             gap;
        whpg_pkg::t_out model_cmd;
        gap = calm ? 0
            : ($urandom_range(0, 9) < 6) ? 0
            : ($urandom_range(0, 19) == 0) ? $urandom_range(30, 300)
            : $urandom_range(1, 4);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= d;
        do @(posedge i_clk); while (o_stall);
        // beat taken: predictor always runs so PID memory stays in step
        model_cmd = guidance_tick(d);
        pending_cmds.push_back(typed ? typed_cmd : model_cmd);
    endtask

    // Gains are only touched once every command beat has come back.
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Leaves the write enable high; the caller drops it after the last write.
    task automatic write_gain(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            whpg_pkg::CFG_KP:  kp_gain = longint'(signed'(val));
            whpg_pkg::CFG_KI:  ki_gain = longint'(signed'(val));
            whpg_pkg::CFG_KD:  kd_gain = longint'(signed'(val));
            default: ;      // spare index, nothing behind it
        endcase
    endtask

    function automatic whpg_pkg::t_in make_tick(input int pn, input int pe, input int tn,
                                                input int te, input int hd);
        whpg_pkg::t_in d;
        d.pos_north    = pn;
        d.pos_east     = pe;
        d.target_north = tn;
        d.target_east  = te;
        d.heading      = hd[15:0];
        return d;
    endfunction

    // Random tick: mostly realistic geometry, some full-range noise.
    function automatic whpg_pkg::t_in random_tick();
        whpg_pkg::t_in d;
        int            kind;
        kind = $urandom_range(0, 9);
        d.pos_north = int'($urandom_range(0, 1 << 23)) - (1 << 22);
        d.pos_east  = int'($urandom_range(0, 1 << 23)) - (1 << 22);
        d.heading   = 16'($urandom_range(0, 35999));
        case (kind)
            7: begin        // anything at all
                d.pos_north    = $urandom;
                d.pos_east     = $urandom;
                d.target_north = $urandom;
                d.target_east  = $urandom;
                d.heading      = 16'($urandom);
            end
            8: begin        // sitting on the waypoint
                d.target_north = d.pos_north;
                d.target_east  = d.pos_east;
            end
            9: begin        // far waypoint
                d.target_north = d.pos_north + int'($urandom_range(0, 1 << 29)) - (1 << 28);
                d.target_east  = d.pos_east + int'($urandom_range(0, 1 << 29)) - (1 << 28);
            end
            default: begin  // within a few hundred metres
                d.target_north = d.pos_north + int'($urandom_range(0, 1 << 17)) - (1 << 16);
                d.target_east  = d.pos_east + int'($urandom_range(0, 1 << 17)) - (1 << 16);
            end
        endcase
        return d;
    endfunction

    typedef struct {
        whpg_pkg::t_in  d;
        bit             typed;    // expected beat written out below
        whpg_pkg::t_out cmd;
    } dir_row_t;

    dir_row_t dir_rows[$];

    localparam int QMAX = 32'h7FFF_FFFF;
    localparam int QMIN = 32'h8000_0000;

    // gain settings walked after the directed table: kp, ki, kd
    localparam int GAIN_SETS [0:6][0:2] = '{
        '{60000, 4000, 20000},
        '{QMAX, QMAX, QMAX},
        '{QMIN, QMIN, QMIN},
        '{QMAX, QMIN, 0},
        '{-45000, -3000, -12000},
        '{0, 0, 0},
        '{150000, 900, 70000}
    };

    initial begin
        whpg_pkg::t_out zero_cmd;
        int             per_set;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_data       = '0;
        i_stall      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = whpg_pkg::CFG_KP;
        i_cfg_data   = '0;
        kp_gain      = 0;
        ki_gain      = 0;
        kd_gain      = 0;
        err_integral = 0;
        last_error   = 0;
        mismatches   = 0;
        idle_cycles  = 0;
        stall_left   = 0;
        calm         = 1'b0;
        zero_cmd     = '0;

        // Directed table. With reset gains every turn command is zero, so
        // a target on the vessel gives an all-zero beat for any heading.
        dir_rows.push_back('{make_tick(0, 0, 0, 0, 0), 1, zero_cmd});
        dir_rows.push_back('{make_tick(QMIN, QMAX, QMIN, QMAX, 35999), 1, zero_cmd});
        dir_rows.push_back('{make_tick(5, -7, 5, -7, 40000), 1, zero_cmd});
        dir_rows.push_back('{make_tick(0, 0, 256, 0, 0), 0, zero_cmd});
        dir_rows.push_back('{make_tick(0, 0, 0, 256, 9000), 0, zero_cmd});
        dir_rows.push_back('{make_tick(0, 0, -256, 0, 18000), 0, zero_cmd});
        dir_rows.push_back('{make_tick(0, 0, 0, -256, 27000), 0, zero_cmd});
        // error beyond +180 and below -180, wrapped once
        dir_rows.push_back('{make_tick(0, 0, 256, -256, 0), 0, zero_cmd});
        dir_rows.push_back('{make_tick(0, 0, -256, 256, 35000), 0, zero_cmd});
        // range saturation in both diagonal directions
        dir_rows.push_back('{make_tick(QMIN, QMIN, QMAX, QMAX, 100), 0, zero_cmd});
        dir_rows.push_back('{make_tick(QMAX, QMAX, QMIN, QMIN, 36000), 0, zero_cmd});
        dir_rows.push_back('{make_tick(0, 0, 1000, -3000, 65535), 0, zero_cmd});
        // speed just at and just below the cap (10 m)
        dir_rows.push_back('{make_tick(0, 0, 2560, 0, 0), 0, zero_cmd});
        dir_rows.push_back('{make_tick(0, 0, 2559, 0, 0), 0, zero_cmd});
        // one-lsb offsets, including the pure negative-north case
        dir_rows.push_back('{make_tick(0, 0, 1, 0, 0), 0, zero_cmd});
        dir_rows.push_back('{make_tick(0, 0, 0, -1, 0), 0, zero_cmd});
        dir_rows.push_back('{make_tick(0, 0, -1, 0, 17999), 0, zero_cmd});
        dir_rows.push_back('{make_tick(0, 0, QMIN, QMIN + 1, 22222), 0, zero_cmd});
        dir_rows.push_back('{make_tick(-1, -1, 0, 0, 36001), 0, zero_cmd});
        dir_rows.push_back('{make_tick(300, 300, -300, 300, 13500), 0, zero_cmd});

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k])
            send_tick(dir_rows[k].d, dir_rows[k].typed, dir_rows[k].cmd);
        drain();

        per_set = N_RANDOM / 7;
        for (int s = 0; s < 7; s++) begin
            write_gain(whpg_pkg::CFG_KP, GAIN_SETS[s][0]);
            write_gain(whpg_pkg::CFG_KI, GAIN_SETS[s][1]);
            write_gain(whpg_pkg::CFG_KD, GAIN_SETS[s][2]);
            write_gain(CFG_SPARE, $urandom);   // must change nothing
            i_cfg_we <= 1'b0;
            for (int n = 0; n < per_set; n++) begin
                // stretches with no idling on either side
                if ($urandom_range(0, 59) == 0) calm = ~calm;
                send_tick(random_tick(), 0, zero_cmd);
            end
            calm = 1'b0;
            drain();
        end

        // a few more cycles in case a stray beat is still on its way
        repeat (200) @(posedge i_clk);
        mismatches += pending_cmds.size();
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/whpg_pkg.sv
hdl/whpg_mul.sv
hdl/waypoint_heading_pid_guidance.sv
hdl/whpg_checker.sv
sim/tb.sv
